@@ design/axis_angle_rotation_matrix_top_assert.svh @@
// assertion macros shared by the rotation matrix design
`ifndef AXIS_ANGLE_ROTATION_MATRIX_TOP_ASSERT_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_TOP_ASSERT_SVH

// implication checked in the same cycle
`define AARM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("aarm assertion failed");

// implication checked in the next cycle
`define AARM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("aarm assertion failed");

`endif

@@ design/aarm_pkg.sv @@
// shared types, constants and arithmetic helpers for the rotation matrix pipeline
`default_nettype none
package aarm_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int FRAC_BITS_DEF    = 14;
   localparam int NEWTON_ITERS     = 5;
   localparam int ATAN_LEN         = 24;
   localparam int QW               = 34;
   localparam int ZW               = 36;

   typedef logic signed [QW-1:0]   q_type;
   typedef logic signed [ZW-1:0]   z_type;
   typedef logic signed [2*QW-1:0] prod_type;

   localparam q_type    Q30_ONE     = 34'sd1073741824;
   localparam q_type    Q30_THREE   = 34'sd3221225472;
   localparam q_type    INV_GAIN    = 34'sd652032874;
   localparam q_type    SEED_LOW_M  = 34'sd912680550;
   localparam q_type    SEED_HIGH_M = 34'sd644245094;
   localparam z_type    Q30_PI      = 36'sd3373259426;
   localparam z_type    Q30_HALF_PI = 36'sd1686629713;
   localparam prod_type RND_Q30     = 68'sd536870912;

   // payload carried along the normaliser cells
   typedef struct packed {
      logic signed [15:0] ang;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic               zero;
      logic [3:0]         sh;
   } norm_type;

   // payload carried along the cordic cells
   typedef struct packed {
      q_type ux;
      q_type uy;
      q_type uz;
      logic  zero;
      logic  flip;
   } rot_type;

   function automatic z_type atan_q30(input logic [4:0] i);
      z_type r;
      unique case (i)
         5'd0:  r = 36'sd843314856;
         5'd1:  r = 36'sd497837829;
         5'd2:  r = 36'sd263043836;
         5'd3:  r = 36'sd133525158;
         5'd4:  r = 36'sd67021686;
         5'd5:  r = 36'sd33543515;
         5'd6:  r = 36'sd16775850;
         5'd7:  r = 36'sd8388437;
         5'd8:  r = 36'sd4194282;
         5'd9:  r = 36'sd2097149;
         5'd10: r = 36'sd1048575;
         5'd11: r = 36'sd524287;
         5'd12: r = 36'sd262143;
         5'd13: r = 36'sd131071;
         5'd14: r = 36'sd65535;
         5'd15: r = 36'sd32767;
         5'd16: r = 36'sd16383;
         5'd17: r = 36'sd8191;
         5'd18: r = 36'sd4095;
         5'd19: r = 36'sd2047;
         5'd20: r = 36'sd1023;
         5'd21: r = 36'sd511;
         5'd22: r = 36'sd255;
         5'd23: r = 36'sd127;
         default: r = '0;
      endcase
      return r;
   endfunction

   // q30 product, rounded half up
   function automatic q_type mul_q30(input q_type a, input q_type b);
      prod_type p;
      p = a * b;
      p = p + RND_Q30;
      return q_type'(p >>> 30);
   endfunction

   // largest output code for a given fraction width
   function automatic int field_hi(input int fb);
      longint one;
      one = longint'(1) << fb;
      return (one > 32767) ? 32767 : int'(one);
   endfunction

   function automatic int field_lo(input int fb);
      longint one;
      one = longint'(1) << fb;
      return (one > 32768) ? -32768 : -int'(one);
   endfunction

endpackage
`default_nettype wire

@@ design/aarm_newton_cell.sv @@
// one newton step of the reciprocal square root, three registered stages
`default_nettype none
module aarm_newton_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire aarm_pkg::q_type  in_m,
   input  wire aarm_pkg::q_type  in_y,
   input  wire aarm_pkg::norm_type in_pl,
   output logic                  out_valid,
   output aarm_pkg::q_type       out_m,
   output aarm_pkg::q_type       out_y,
   output aarm_pkg::norm_type    out_pl
);

   logic               v1_ff, v2_ff, v3_ff;
   logic               v1_in, v2_in, v3_in;
   aarm_pkg::q_type    m1_ff, m2_ff, m3_ff;
   aarm_pkg::q_type    y1_ff, y2_ff, y3_ff;
   aarm_pkg::q_type    ysq1_ff, my2_ff;
   aarm_pkg::q_type    ysq1_in, my2_in, y3_in;
   aarm_pkg::norm_type pl1_ff, pl2_ff, pl3_ff;
   aarm_pkg::prod_type p1, p2, p3;

   assign v1_in = in_valid;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;

   always_comb begin
      p1      = in_y * in_y;
      ysq1_in = aarm_pkg::q_type'(p1 >>> 30);
      p2      = m1_ff * ysq1_ff;
      my2_in  = aarm_pkg::q_type'(p2 >>> 30);
      p3      = y2_ff * (aarm_pkg::Q30_THREE - my2_ff);
      y3_in   = aarm_pkg::q_type'(p3 >>> 31);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff   <= in_m;
         y1_ff   <= in_y;
         ysq1_ff <= ysq1_in;
         pl1_ff  <= in_pl;
         m2_ff   <= m1_ff;
         y2_ff   <= y1_ff;
         my2_ff  <= my2_in;
         pl2_ff  <= pl1_ff;
         m3_ff   <= m2_ff;
         y3_ff   <= y3_in;
         pl3_ff  <= pl2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_m     = m3_ff;
   assign out_y     = y3_ff;
   assign out_pl    = pl3_ff;

endmodule
`default_nettype wire

@@ design/aarm_cordic_cell.sv @@
// one registered cordic rotation step
`default_nettype none
module aarm_cordic_cell #(
   parameter int STEP = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire aarm_pkg::q_type   in_x,
   input  wire aarm_pkg::q_type   in_y,
   input  wire aarm_pkg::z_type   in_z,
   input  wire aarm_pkg::rot_type in_pl,
   output logic                   out_valid,
   output aarm_pkg::q_type        out_x,
   output aarm_pkg::q_type        out_y,
   output aarm_pkg::z_type        out_z,
   output aarm_pkg::rot_type      out_pl
);

   localparam aarm_pkg::z_type ATAN = aarm_pkg::atan_q30(5'(STEP));

   logic              valid_ff, valid_in;
   aarm_pkg::q_type   x_ff, y_ff, x_in, y_in, dx, dy;
   aarm_pkg::z_type   z_ff, z_in;
   aarm_pkg::rot_type pl_ff;

   assign valid_in = in_valid;

   always_comb begin
      dx = in_y >>> STEP;
      dy = in_x >>> STEP;
      if (!in_z[aarm_pkg::ZW-1]) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ATAN;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         z_ff  <= z_in;
         pl_ff <= in_pl;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_pl    = pl_ff;

endmodule
`default_nettype wire

@@ design/aarm_matrix.sv @@
// rodrigues matrix assembly: three stages ending in the result register
`default_nettype none
module aarm_matrix #(
   parameter int FRAC_BITS = aarm_pkg::FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire aarm_pkg::q_type   in_x,
   input  wire aarm_pkg::q_type   in_y,
   input  wire aarm_pkg::rot_type in_pl,
   output logic                   out_valid,
   output logic [8:0][15:0]       out_ent,
   output logic                   out_zero
);

   localparam int RS = 30 - FRAC_BITS;
   localparam aarm_pkg::z_type RND = aarm_pkg::z_type'((64'sd1 <<< RS) >>> 1);
   localparam aarm_pkg::z_type HI  = aarm_pkg::z_type'(aarm_pkg::field_hi(FRAC_BITS));
   localparam aarm_pkg::z_type LO  = aarm_pkg::z_type'(aarm_pkg::field_lo(FRAC_BITS));

   function automatic logic [15:0] to_field(input aarm_pkg::z_type v);
      aarm_pkg::z_type r;
      r = (v + RND) >>> RS;
      if (r > HI) r = HI;
      if (r < LO) r = LO;
      return r[15:0];
   endfunction

   logic            va_ff, vb_ff, vc_ff;
   logic            va_in, vb_in, vc_in;
   logic            za_ff, zb_ff, zc_ff;
   aarm_pkg::q_type cs_in, sn_in;
   aarm_pkg::q_type cs_a_ff, omc_a_ff, cs_b_ff;
   aarm_pkg::q_type pxx_ff, pyy_ff, pzz_ff, pxy_ff, pxz_ff, pyz_ff;
   aarm_pkg::q_type sx_a_ff, sy_a_ff, sz_a_ff, sx_b_ff, sy_b_ff, sz_b_ff;
   aarm_pkg::q_type qxx_ff, qyy_ff, qzz_ff, qxy_ff, qxz_ff, qyz_ff;
   aarm_pkg::z_type mat [9];
   logic [8:0][15:0] ent_ff, ent_in;

   assign va_in = in_valid;
   assign vb_in = va_ff;
   assign vc_in = vb_ff;

   always_comb begin
      cs_in = in_pl.flip ? -in_x : in_x;
      sn_in = in_pl.flip ? -in_y : in_y;
   end

   always_comb begin
      mat[0] = aarm_pkg::z_type'(cs_b_ff) + aarm_pkg::z_type'(qxx_ff);
      mat[1] = aarm_pkg::z_type'(qxy_ff)  - aarm_pkg::z_type'(sz_b_ff);
      mat[2] = aarm_pkg::z_type'(qxz_ff)  + aarm_pkg::z_type'(sy_b_ff);
      mat[3] = aarm_pkg::z_type'(qxy_ff)  + aarm_pkg::z_type'(sz_b_ff);
      mat[4] = aarm_pkg::z_type'(cs_b_ff) + aarm_pkg::z_type'(qyy_ff);
      mat[5] = aarm_pkg::z_type'(qyz_ff)  - aarm_pkg::z_type'(sx_b_ff);
      mat[6] = aarm_pkg::z_type'(qxz_ff)  - aarm_pkg::z_type'(sy_b_ff);
      mat[7] = aarm_pkg::z_type'(qyz_ff)  + aarm_pkg::z_type'(sx_b_ff);
      mat[8] = aarm_pkg::z_type'(cs_b_ff) + aarm_pkg::z_type'(qzz_ff);
      for (int k = 0; k < 9; k++) begin
         if (zb_ff) begin
            // identity for a zero axis
            ent_in[k] = (k % 4 == 0) ? HI[15:0] : 16'd0;
         end else begin
            ent_in[k] = to_field(mat[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (en) begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vc_ff <= vc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         za_ff    <= in_pl.zero;
         cs_a_ff  <= cs_in;
         omc_a_ff <= aarm_pkg::Q30_ONE - cs_in;
         pxx_ff   <= aarm_pkg::mul_q30(in_pl.ux, in_pl.ux);
         pyy_ff   <= aarm_pkg::mul_q30(in_pl.uy, in_pl.uy);
         pzz_ff   <= aarm_pkg::mul_q30(in_pl.uz, in_pl.uz);
         pxy_ff   <= aarm_pkg::mul_q30(in_pl.ux, in_pl.uy);
         pxz_ff   <= aarm_pkg::mul_q30(in_pl.ux, in_pl.uz);
         pyz_ff   <= aarm_pkg::mul_q30(in_pl.uy, in_pl.uz);
         sx_a_ff  <= aarm_pkg::mul_q30(in_pl.ux, sn_in);
         sy_a_ff  <= aarm_pkg::mul_q30(in_pl.uy, sn_in);
         sz_a_ff  <= aarm_pkg::mul_q30(in_pl.uz, sn_in);
         zb_ff    <= za_ff;
         cs_b_ff  <= cs_a_ff;
         sx_b_ff  <= sx_a_ff;
         sy_b_ff  <= sy_a_ff;
         sz_b_ff  <= sz_a_ff;
         qxx_ff   <= aarm_pkg::mul_q30(pxx_ff, omc_a_ff);
         qyy_ff   <= aarm_pkg::mul_q30(pyy_ff, omc_a_ff);
         qzz_ff   <= aarm_pkg::mul_q30(pzz_ff, omc_a_ff);
         qxy_ff   <= aarm_pkg::mul_q30(pxy_ff, omc_a_ff);
         qxz_ff   <= aarm_pkg::mul_q30(pxz_ff, omc_a_ff);
         qyz_ff   <= aarm_pkg::mul_q30(pyz_ff, omc_a_ff);
         zc_ff    <= zb_ff;
         ent_ff   <= ent_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_ent   = ent_ff;
   assign out_zero  = zc_ff;

endmodule
`default_nettype wire

@@ design/axis_angle_rotation_matrix_top.sv @@
// axis-angle to rotation matrix pipeline, top level
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | angle, axis x/y/z
//   rsp     | out       | rsp_valid/rsp_stall | m00..m22, zero_axis
//
// one transaction enters per cycle while req_stall is low
// the pipeline holds five three-stage newton cells and one cordic cell per step
// reset clears only the valid bits along the pipeline
// a stalled result holds the whole pipeline, and req_stall follows it in the same cycle
`default_nettype none
module axis_angle_rotation_matrix_top #(
   parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = aarm_pkg::FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_angle,
   input  wire logic signed [15:0] req_axis_x,
   input  wire logic signed [15:0] req_axis_y,
   input  wire logic signed [15:0] req_axis_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_m00,
   output logic signed [15:0]      rsp_m01,
   output logic signed [15:0]      rsp_m02,
   output logic signed [15:0]      rsp_m10,
   output logic signed [15:0]      rsp_m11,
   output logic signed [15:0]      rsp_m12,
   output logic signed [15:0]      rsp_m20,
   output logic signed [15:0]      rsp_m21,
   output logic signed [15:0]      rsp_m22,
   output logic                    rsp_zero_axis
);

`include "axis_angle_rotation_matrix_top_assert.svh"

   localparam int STEPS = (CORDIC_STEPS > aarm_pkg::ATAN_LEN) ? aarm_pkg::ATAN_LEN
                                                              : CORDIC_STEPS;
   localparam int NI    = aarm_pkg::NEWTON_ITERS;
   localparam logic signed [15:0] F_HI = 16'(aarm_pkg::field_hi(FRAC_BITS));
   localparam logic signed [15:0] F_LO = 16'(aarm_pkg::field_lo(FRAC_BITS));

   logic en;

   // stage 0: squares
   logic               v0_ff, v1_ff, v2_ff, vu_ff;
   logic [31:0]        ss0_ff, ss0_in, ss1_ff;
   logic signed [31:0] sqx, sqy, sqz;
   aarm_pkg::norm_type pl0_ff, pl0_in, pl1_ff, pl1_in, pl2_ff;

   // stage 1: leading one and even shift
   logic [4:0] lead, kt, k1_ff, k1_in;

   // stage 2: normalised m and seed
   aarm_pkg::q_type m2_ff, m2_in, y2_ff, y2_in;

   // newton chain
   logic               nv [NI+1];
   aarm_pkg::q_type    nm [NI+1];
   aarm_pkg::q_type    ny [NI+1];
   aarm_pkg::norm_type npl [NI+1];

   // unit vector and cordic preparation
   logic signed [49:0] px, py, pz, rnd;
   aarm_pkg::z_type    z0, zu_ff, zu_in;
   aarm_pkg::rot_type  rpu_ff, rpu_in;

   // cordic chain
   logic              cv [STEPS+1];
   aarm_pkg::q_type   cx [STEPS+1];
   aarm_pkg::q_type   cy [STEPS+1];
   aarm_pkg::z_type   cz [STEPS+1];
   aarm_pkg::rot_type cpl [STEPS+1];

   logic [8:0][15:0] ent;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      sqx    = req_axis_x * req_axis_x;
      sqy    = req_axis_y * req_axis_y;
      sqz    = req_axis_z * req_axis_z;
      ss0_in = 32'(sqx) + 32'(sqy) + 32'(sqz);
      pl0_in.ang  = req_angle;
      pl0_in.ax   = req_axis_x;
      pl0_in.ay   = req_axis_y;
      pl0_in.az   = req_axis_z;
      pl0_in.zero = (req_axis_x == 16'sd0) && (req_axis_y == 16'sd0)
                    && (req_axis_z == 16'sd0);
      pl0_in.sh   = '0;
   end

   always_comb begin
      lead = '0;
      for (int i = 0; i < 32; i++) begin
         if (ss0_ff[i]) lead = 5'(i);
      end
      // smallest even shift that brings the top bit to bit 30 or 31
      kt = (lead >= 5'd30) ? 5'd0 : (5'd30 - lead + {4'd0, lead[0]});
      k1_in     = {kt[4:1], 1'b0};
      pl1_in    = pl0_ff;
      pl1_in.sh = 4'd15 - kt[4:1];
   end

   always_comb begin
      m2_in = aarm_pkg::q_type'({2'b00, ss1_ff} << k1_ff);
      y2_in = (m2_in[aarm_pkg::QW-1:31] == '0) ? aarm_pkg::SEED_LOW_M
                                               : aarm_pkg::SEED_HIGH_M;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vu_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         vu_ff <= nv[NI];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ss0_ff <= ss0_in;
         pl0_ff <= pl0_in;
         ss1_ff <= ss0_ff;
         k1_ff  <= k1_in;
         pl1_ff <= pl1_in;
         m2_ff  <= m2_in;
         y2_ff  <= y2_in;
         pl2_ff <= pl1_ff;
         zu_ff  <= zu_in;
         rpu_ff <= rpu_in;
      end
   end

   assign nv[0]  = v2_ff;
   assign nm[0]  = m2_ff;
   assign ny[0]  = y2_ff;
   assign npl[0] = pl2_ff;

   for (genvar g = 0; g < NI; g++) begin : g_newton
      aarm_newton_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (nv[g]),
         .in_m      (nm[g]),
         .in_y      (ny[g]),
         .in_pl     (npl[g]),
         .out_valid (nv[g+1]),
         .out_m     (nm[g+1]),
         .out_y     (ny[g+1]),
         .out_pl    (npl[g+1])
      );
   end

   always_comb begin
      px  = npl[NI].ax * ny[NI];
      py  = npl[NI].ay * ny[NI];
      pz  = npl[NI].az * ny[NI];
      rnd = (npl[NI].sh == 4'd0) ? 50'sd0 : (50'sd1 <<< (npl[NI].sh - 4'd1));
      rpu_in.ux   = aarm_pkg::q_type'((px + rnd) >>> npl[NI].sh);
      rpu_in.uy   = aarm_pkg::q_type'((py + rnd) >>> npl[NI].sh);
      rpu_in.uz   = aarm_pkg::q_type'((pz + rnd) >>> npl[NI].sh);
      rpu_in.zero = npl[NI].zero;
      z0 = aarm_pkg::z_type'(npl[NI].ang) <<< 17;
      // fold angles beyond a quarter turn, sign restored after the cordic
      if (z0 > aarm_pkg::Q30_HALF_PI) begin
         zu_in       = z0 - aarm_pkg::Q30_PI;
         rpu_in.flip = 1'b1;
      end else if (z0 < -aarm_pkg::Q30_HALF_PI) begin
         zu_in       = z0 + aarm_pkg::Q30_PI;
         rpu_in.flip = 1'b1;
      end else begin
         zu_in       = z0;
         rpu_in.flip = 1'b0;
      end
   end

   assign cv[0]  = vu_ff;
   assign cx[0]  = aarm_pkg::INV_GAIN;
   assign cy[0]  = '0;
   assign cz[0]  = zu_ff;
   assign cpl[0] = rpu_ff;

   for (genvar g = 0; g < STEPS; g++) begin : g_cordic
      aarm_cordic_cell #(
         .STEP (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cv[g]),
         .in_x      (cx[g]),
         .in_y      (cy[g]),
         .in_z      (cz[g]),
         .in_pl     (cpl[g]),
         .out_valid (cv[g+1]),
         .out_x     (cx[g+1]),
         .out_y     (cy[g+1]),
         .out_z     (cz[g+1]),
         .out_pl    (cpl[g+1])
      );
   end

   aarm_matrix #(
      .FRAC_BITS (FRAC_BITS)
   ) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cv[STEPS]),
      .in_x      (cx[STEPS]),
      .in_y      (cy[STEPS]),
      .in_pl     (cpl[STEPS]),
      .out_valid (rsp_valid),
      .out_ent   (ent),
      .out_zero  (rsp_zero_axis)
   );

   assign rsp_m00 = ent[0];
   assign rsp_m01 = ent[1];
   assign rsp_m02 = ent[2];
   assign rsp_m10 = ent[3];
   assign rsp_m11 = ent[4];
   assign rsp_m12 = ent[5];
   assign rsp_m20 = ent[6];
   assign rsp_m21 = ent[7];
   assign rsp_m22 = ent[8];

   `AARM_ASSERT_NOW(a_zero_identity, rsp_valid && rsp_zero_axis, rsp_m00 == F_HI && rsp_m11 == F_HI && rsp_m22 == F_HI && rsp_m01 == 16'sd0 && rsp_m12 == 16'sd0 && rsp_m20 == 16'sd0)
   `AARM_ASSERT_NOW(a_m00_range, rsp_valid, rsp_m00 <= F_HI && rsp_m00 >= F_LO)
   `AARM_ASSERT_NOW(a_m12_range, rsp_valid, rsp_m12 <= F_HI && rsp_m12 >= F_LO)
   `AARM_ASSERT_NEXT(a_stall_holds_front, rsp_valid && rsp_stall && v0_ff, v0_ff)

endmodule
`default_nettype wire

@@ dv/axis_angle_rotation_matrix_top_test.sv @@
// self-checking testbench for the axis-angle rotation matrix pipeline
module axis_angle_rotation_matrix_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS = 16;
   localparam int FBITS = 14;
   localparam int LATENCY = 22 + STEPS;

   typedef struct {
      logic signed [15:0] m [9];
      logic               zero_axis;
   } matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_angle = '0, req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   logic signed [15:0] rsp_m20, rsp_m21, rsp_m22;
   logic rsp_zero_axis;

   matrix_type expected_matrices [$];
   int fail_count = 0;
   bit stall_enable = 1'b1;

   axis_angle_rotation_matrix_top #(.CORDIC_STEPS(STEPS), .FRAC_BITS(FBITS)) DUT (.*);

   always #1 clock = ~clock;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_to(longint v, int s);
      if (s == 0) return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return round_to(a * b, 30);
   endfunction

   function automatic logic signed [15:0] to_entry(longint q);
      longint one, hi, lo, v;
      one = longint'(1) << FBITS;
      hi = (one > 32767) ? 32767 : one;
      lo = (-one < -32768) ? -32768 : -one;
      v = round_to(q, 30 - FBITS);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[15:0];
   endfunction

   function automatic longint atan_entry(int i);
      longint tbl [24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
         33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
         131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
      return tbl[i];
   endfunction

   function automatic matrix_type rotation_matrix(logic signed [15:0] ang,
         logic signed [15:0] ax, logic signed [15:0] ay, logic signed [15:0] az);
      matrix_type r;
      longint a [9];
      longint x, y, z, ss, m, nr, y2, my2, ux, uy, uz, sn, cs, omc, dx, dy;
      longint vx, vy, vz;
      int e, sh;
      bit flip;
      vx = ax; vy = ay; vz = az;
      ss = vx * vx + vy * vy + vz * vz;
      if (ss == 0) begin
         for (int k = 0; k < 9; k++) a[k] = (k % 4 == 0) ? (longint'(1) << 30) : 0;
         r.zero_axis = 1'b1;
      end else begin
         e = 0;
         while ((ss << e) < (longint'(1) << 60)) e += 2;
         m = (ss << e) >>> 30;
         nr = (m < 2 * (longint'(1) << 30)) ? 912680550 : 644245094;
         for (int k = 0; k < 5; k++) begin
            y2 = floor_shift(nr * nr, 30);
            my2 = floor_shift(m * y2, 30);
            nr = floor_shift(nr * (3 * (longint'(1) << 30) - my2), 31);
         end
         sh = 30 - e / 2;
         ux = round_to(vx * nr, sh);
         uy = round_to(vy * nr, sh);
         uz = round_to(vz * nr, sh);
         // cordic with quadrant fold
         x = 652032874; y = 0; z = longint'(ang) * 131072; flip = 0;
         if (z > 64'sd1686629713) begin z -= 64'sd3373259426; flip = 1; end
         else if (z < -64'sd1686629713) begin z += 64'sd3373259426; flip = 1; end
         for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin x -= dx; y += dy; z -= atan_entry(i); end
            else begin x += dx; y -= dy; z += atan_entry(i); end
         end
         cs = flip ? -x : x;
         sn = flip ? -y : y;
         omc = (longint'(1) << 30) - cs;
         a[0] = cs + qmul(qmul(ux, ux), omc);
         a[1] = qmul(qmul(ux, uy), omc) - qmul(uz, sn);
         a[2] = qmul(qmul(ux, uz), omc) + qmul(uy, sn);
         a[3] = qmul(qmul(uy, ux), omc) + qmul(uz, sn);
         a[4] = cs + qmul(qmul(uy, uy), omc);
         a[5] = qmul(qmul(uy, uz), omc) - qmul(ux, sn);
         a[6] = qmul(qmul(uz, ux), omc) - qmul(uy, sn);
         a[7] = qmul(qmul(uz, uy), omc) + qmul(ux, sn);
         a[8] = cs + qmul(qmul(uz, uz), omc);
         r.zero_axis = 1'b0;
      end
      for (int k = 0; k < 9; k++) r.m[k] = to_entry(a[k]);
      return r;
   endfunction

   task automatic send_transform(logic signed [15:0] ang, logic signed [15:0] ax,
         logic signed [15:0] ay, logic signed [15:0] az, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_angle <= ang; req_axis_x <= ax; req_axis_y <= ay; req_axis_z <= az;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_matrices.push_back(rotation_matrix(ang, ax, ay, az));
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_matrices.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // receiver back-pressure, redrawn after each transaction
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         hold = stall_enable ? $urandom_range(0, 19) : 0;
         if ($urandom_range(0, 3) == 0) hold = 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      matrix_type want;
      logic signed [15:0] got [9];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12,
                 rsp_m20, rsp_m21, rsp_m22};
         if (expected_matrices.size() == 0) begin
            $error("unexpected transaction on result channel");
            fail_count++;
         end else begin
            want = expected_matrices.pop_front();
            for (int k = 0; k < 9; k++)
               if (got[k] !== want.m[k]) begin
                  $error("m%0d%0d expected %0d actual %0d", k / 3, k % 3, want.m[k], got[k]);
                  fail_count++;
               end
            if (rsp_zero_axis !== want.zero_axis) begin
               $error("zero_axis expected %0d actual %0d", want.zero_axis, rsp_zero_axis);
               fail_count++;
            end
         end
      end
   end

   task automatic test_directed();
      logic signed [15:0] angles [6] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd32767,
         16'sh8000, 16'sd12868};
      send_transform(16'sd1000, 16'sd0, 16'sd0, 16'sd0);
      send_transform(16'sh8000, 16'sd0, 16'sd0, 16'sd0);
      foreach (angles[i]) send_transform(angles[i], 16'sd1, 16'sd0, 16'sd0);
      send_transform(16'sd12868, 16'sd0, 16'sh8000, 16'sd0);
      send_transform(-16'sd12869, 16'sd0, 16'sd0, 16'sd32767);
      send_transform(16'sd12869, 16'sh8000, 16'sh8000, 16'sh8000);
      send_transform(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
      send_transform(16'sh8000, 16'sd1, -16'sd1, 16'sd1);
      send_transform(16'sd5000, 16'sd3, 16'sd4, 16'sd0);
      send_transform(-16'sd1, -16'sd1, 16'sd0, 16'sd0);
      end_burst();
   endtask

   task automatic test_back_to_back();
      stall_enable = 0;
      repeat (200)
         send_transform(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1);
      end_burst();
      stall_enable = 1;
   endtask

   task automatic test_random(int count);
      logic signed [15:0] ang, ax, ay, az;
      for (int n = 0; n < count; n++) begin
         ang = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                           : 16'($signed($urandom_range(0, 51472)) - 25736);
         ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
         case ($urandom_range(0, 9))
            0: begin ax = 16'sd0; ay = 16'sd0; az = 16'sd0; end
            1: begin
               ax = 16'($signed($urandom_range(0, 6)) - 3);
               ay = 16'sd0;
               az = 16'sd0;
            end
            2: begin ay = 16'($signed($urandom_range(0, 20)) - 10); az = 16'sd0; end
            default: ;
         endcase
         send_transform(ang, ax, ay, az, $urandom_range(0, 4) == 0);
         // sender holds off until the pipeline has emptied
         if (n == count / 2) begin
            end_burst();
            while (expected_matrices.size() != 0) @(posedge clock);
         end
      end
      end_burst();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_back_to_back();
      test_random(1700);
      wait_drained();
      if (fail_count == 0)
         $display("axis_angle_rotation_matrix_top_test OK");
      else
         $display("axis_angle_rotation_matrix_top_test NOT OK");
      $finish;
   end

   initial begin
      #2000000;
      $display("axis_angle_rotation_matrix_top_test NOT OK");
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+design
design/aarm_pkg.sv
design/aarm_newton_cell.sv
design/aarm_cordic_cell.sv
design/aarm_matrix.sv
design/axis_angle_rotation_matrix_top.sv
dv/axis_angle_rotation_matrix_top_test.sv
